// ----- hdl/apkt_pkg.sv -----
// Shared types and constants for the audio packetizer with underrun fade.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package apkt_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W   = 16;
  localparam int COUNT_W    = 16;
  localparam int PLEN_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Default store depth in samples
  localparam int MAX_PACKET_SAMPLES_DEF = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STREAM_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LENGTH = 1'd1;

  // Input function codes
  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Input word
  typedef struct packed {
    logic                       func;
    logic signed [SAMPLE_W-1:0] sample_in;
  } req_t;

  // Output word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_packet;
    logic                       short_packet;
    logic [COUNT_W-1:0]         underrun_total;
  } rsp_t;

endpackage

// ----- hdl/apkt_store.sv -----
// Packet sample store: one write port, one read port with registered data.
// Depends on apkt_pkg for the sample width.
`timescale 1ns / 1ps

module apkt_store import apkt_pkg::*; #(
  parameter int DEPTH = MAX_PACKET_SAMPLES_DEF,
  parameter int IDX_W = 4
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_addr,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  // Write a pushed sample
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, data valid the cycle after rd_en; hold the data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/apkt_fade.sv -----
// Fade tail generator: start*num/den truncated toward zero, one multiply
// followed by a bit-serial restoring divide. Depends on apkt_pkg.
`timescale 1ns / 1ps

module apkt_fade import apkt_pkg::*; #(
  parameter int LEN_W = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic signed [SAMPLE_W-1:0] start,
  input  logic [LEN_W-1:0]           num,
  input  logic [LEN_W-1:0]           den,
  output logic                       done,
  output logic signed [SAMPLE_W-1:0] value
);

  localparam int PROD_W = SAMPLE_W + LEN_W;
  localparam int CNT_W  = $clog2(PROD_W);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_DIV  = 2'd2;

  logic [1:0]          state;
  logic                neg;
  logic [SAMPLE_W-1:0] mag;
  logic [LEN_W-1:0]    num_r;
  logic [LEN_W-1:0]    den_r;
  logic [PROD_W-1:0]   quo;
  logic [LEN_W:0]      rem;
  logic [CNT_W-1:0]    cnt;
  logic [SAMPLE_W:0]   start_ext;
  logic [LEN_W:0]      rem_sh;
  logic                ge;

  assign start_ext = {start[SAMPLE_W-1], start};

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh = {rem[LEN_W-1:0], quo[PROD_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  // Sequence multiply then divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (go) state <= F_MUL;
        F_MUL:  state <= F_DIV;
        F_DIV:  if (cnt == '0) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath: take magnitude, form product, shift out quotient bits
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (go) begin
          neg   <= start[SAMPLE_W-1];
          mag   <= start[SAMPLE_W-1] ? SAMPLE_W'(-start_ext) : SAMPLE_W'(start_ext);
          num_r <= num;
          den_r <= den;
        end
      end
      F_MUL: begin
        quo <= PROD_W'(mag) * PROD_W'(num_r);
        rem <= '0;
        cnt <= CNT_W'(PROD_W - 1);
      end
      F_DIV: begin
        quo <= {quo[PROD_W-2:0], ge};
        rem <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase
  end

  assign done  = (state == F_DIV) && (cnt == '0);
  assign value = neg ? -$signed(quo[SAMPLE_W-1:0]) : $signed(quo[SAMPLE_W-1:0]);

endmodule

// ----- hdl/audio_packetizer_underrun_fade_top.sv -----
// Audio packetizer with underrun fade: control sequencer, registers and
// output stage. Instantiates apkt_store and apkt_fade; depends on apkt_pkg.
//
// Usage:
//   req channel carries a word with func and sample_in. func push appends
//   the sample to the packet store (dropped when the store already holds
//   the configured packet length); func tick ends the packet period.
//   A tick with stream_enable set sends the whole packet on the rsp channel,
//   one sample per word, stored samples first and then a linear fade toward
//   zero for any missing tail. A tick with streaming off clears the fill
//   level and the last output sample and sends nothing.
//   cfg channel writes stream_enable (index 0) and packet_length (index 1);
//   it is always ready and is meant to be written while the block is idle.
// Sequencing:
//   A push is taken in S_IDLE. A streaming tick steps through S_START (with a
//   stored sample), S_NEXT and S_RDATA per stored sample, and S_NEXT, S_FADE
//   and S_FOUT per fade sample (one multiply, then a one-bit-per-cycle divide);
//   the divide sets packet time. req_ready is high only between packets.
// Reset and stall:
//   Synchronous reset clears fill level, last sample, underrun count and the
//   registers (streaming off, length 16). When rsp_ready is low the current
//   word holds in the output register and the sequencer waits.
`timescale 1ns / 1ps

module audio_packetizer_underrun_fade_top import apkt_pkg::*; #(
  parameter int MAX_PACKET_SAMPLES = MAX_PACKET_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LEN_W = $clog2(MAX_PACKET_SAMPLES + 1);
  localparam int IDX_W = (MAX_PACKET_SAMPLES > 1) ? $clog2(MAX_PACKET_SAMPLES) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_NEXT  = 3'd2;
  localparam logic [2:0] S_RDATA = 3'd3;
  localparam logic [2:0] S_FADE  = 3'd4;
  localparam logic [2:0] S_FOUT  = 3'd5;

  logic [2:0]                 state;
  logic                       stream_enable;
  logic [PLEN_W-1:0]          packet_length;
  logic [LEN_W-1:0]           fill;
  logic signed [SAMPLE_W-1:0] prev;
  logic [COUNT_W-1:0]         under;
  logic [LEN_W-1:0]           len_r;
  logic [LEN_W-1:0]           filled_r;
  logic                       short_r;
  logic [LEN_W-1:0]           idx;
  logic signed [SAMPLE_W-1:0] start_r;

  logic [LEN_W-1:0]           len;
  logic [LEN_W-1:0]           filled;
  logic                       accept;
  logic                       slot_free;
  logic                       emit;
  logic signed [SAMPLE_W-1:0] emit_sample;
  logic                       is_last;

  logic                       wr_en;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;

  logic                       fade_go;
  logic                       fade_done;
  logic signed [SAMPLE_W-1:0] fade_value;
  logic [LEN_W-1:0]           fade_num;
  logic [LEN_W-1:0]           fade_den;

  // Clamp the packet length to 1..depth
  always_comb begin
    if ({2'b00, packet_length} > 7'(MAX_PACKET_SAMPLES)) begin
      len = LEN_W'(MAX_PACKET_SAMPLES);
    end else if (packet_length == '0) begin
      len = LEN_W'(1);
    end else begin
      len = LEN_W'(packet_length);
    end
  end

  assign filled    = (fill < len) ? fill : len;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign cfg_ready = 1'b1;
  assign slot_free = !rsp_valid || rsp_ready;
  assign is_last   = (idx == len_r - 1'b1);

  // Pick the word to send and when
  always_comb begin
    emit        = 1'b0;
    emit_sample = rd_data;
    if (state == S_RDATA) begin
      emit = slot_free;
    end else if (state == S_FOUT) begin
      emit        = slot_free;
      emit_sample = fade_value;
    end
  end

  // Memory port control
  assign wr_en = accept && (req.func == FUNC_PUSH) && (fill < len);
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx[IDX_W-1:0];
    if (accept && (req.func == FUNC_TICK) && stream_enable && (filled != '0)) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(filled - 1'b1);
    end else if ((state == S_NEXT) && (idx < filled_r)) begin
      rd_en = 1'b1;
    end
  end

  assign fade_go  = (state == S_NEXT) && !(idx < filled_r);
  assign fade_num = len_r - 1'b1 - idx;
  assign fade_den = len_r - filled_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_enable <= 1'b0;
      packet_length <= PLEN_W'(16);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STREAM_ENABLE: stream_enable <= cfg_data[0];
        REG_PACKET_LENGTH: packet_length <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequence pushes, ticks and packet readout
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      prev  <= '0;
      under <= '0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.func == FUNC_PUSH) begin
              if (fill < len) fill <= fill + 1'b1;
            end else if (!stream_enable) begin
              fill <= '0;
              prev <= '0;
            end else begin
              if ((filled < len) && (under != '1)) under <= under + 1'b1;
              idx   <= '0;
              state <= (filled != '0) ? S_START : S_NEXT;
            end
          end
        end
        S_START: state <= S_NEXT;
        S_NEXT:  state <= (idx < filled_r) ? S_RDATA : S_FADE;
        S_FADE:  if (fade_done) state <= S_FOUT;
        S_RDATA, S_FOUT: begin
          if (emit) begin
            if (is_last) begin
              prev  <= emit_sample;
              fill  <= '0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_NEXT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold packet parameters for the readout
  always_ff @(posedge clk) begin
    if (accept && (req.func == FUNC_TICK)) begin
      len_r    <= len;
      filled_r <= filled;
      short_r  <= (filled < len);
      start_r  <= prev;
    end else if (state == S_START) begin
      start_r <= rd_data;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.sample_out     <= emit_sample;
      rsp.last_of_packet <= is_last;
      rsp.short_packet   <= short_r;
      rsp.underrun_total <= under;
    end
  end

  apkt_store #(
    .DEPTH (MAX_PACKET_SAMPLES),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[IDX_W-1:0]),
    .wr_data (req.sample_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  apkt_fade #(
    .LEN_W (LEN_W)
  ) u_fade (
    .clk   (clk),
    .rst   (rst),
    .go    (fade_go),
    .start (start_r),
    .num   (fade_num),
    .den   (fade_den),
    .done  (fade_done),
    .value (fade_value)
  );

endmodule

// ----- dv/apkt_checker.sv -----
// Checker for the audio packetizer: watches the req, rsp and cfg channels,
// predicts every packet word and compares. Depends on apkt_pkg.
`timescale 1ns / 1ps

module apkt_checker import apkt_pkg::*; #(
  parameter int DEPTH = MAX_PACKET_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  rsp_t                  rsp,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    outstanding
);

  localparam logic [PLEN_W-1:0] RESET_PACKET_LEN = PLEN_W'(16);

  // Mirror of the block state and registers
  logic signed [SAMPLE_W-1:0] held_samples [DEPTH];
  int                         held_count = 0;
  logic signed [SAMPLE_W-1:0] last_sent = '0;
  logic [COUNT_W-1:0]         short_total = '0;
  logic                       streaming = 1'b0;
  logic [PLEN_W-1:0]          packet_len = RESET_PACKET_LEN;

  rsp_t expected_words [$];
  int   bad_words = 0;

  // Length 0 behaves as 1, anything above the store depth as the depth
  function automatic int effective_len();
    if (packet_len == 0) return 1;
    if (int'(packet_len) > DEPTH) return DEPTH;
    return int'(packet_len);
  endfunction

  // Linear fade value, truncated toward zero
  function automatic logic signed [SAMPLE_W-1:0] fade_value(int start, int num, int den);
    return SAMPLE_W'((start * num) / den);
  endfunction

  // Work out every word a deadline tick sends and queue them
  task automatic predict_packet();
    int   len;
    int   filled;
    int   tail;
    int   start;
    bit   is_short;
    rsp_t w;
    len = effective_len();
    if (!streaming) begin
      held_count = 0;
      last_sent = '0;
      return;
    end
    filled = (held_count < len) ? held_count : len;
    is_short = filled < len;
    if (is_short && short_total != '1) short_total++;
    start = (filled > 0) ? int'(held_samples[filled-1]) : int'(last_sent);
    tail = len - filled;
    for (int i = 0; i < len; i++) begin
      w.sample_out     = (i < filled) ? held_samples[i]
                                      : fade_value(start, tail - (i - filled) - 1, tail);
      w.last_of_packet = (i == len - 1);
      w.short_packet   = is_short;
      w.underrun_total = short_total;
      expected_words.push_back(w);
    end
    last_sent = w.sample_out;
    held_count = 0;
  endtask

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (rst) begin
      held_count = 0;
      last_sent = '0;
      short_total = '0;
      streaming = 1'b0;
      packet_len = RESET_PACKET_LEN;
      expected_words.delete();
    end else begin
      // Compare first: a word leaving now belongs to an older tick
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: sample_out %0d", rsp.sample_out);
          bad_words++;
        end else begin
          want = expected_words.pop_front();
          if (rsp.sample_out !== want.sample_out) begin
            $error("sample_out: expected %0d, got %0d", want.sample_out, rsp.sample_out);
            bad_words++;
          end
          if (rsp.last_of_packet !== want.last_of_packet) begin
            $error("last_of_packet: expected %0d, got %0d",
                   want.last_of_packet, rsp.last_of_packet);
            bad_words++;
          end
          if (rsp.short_packet !== want.short_packet) begin
            $error("short_packet: expected %0d, got %0d",
                   want.short_packet, rsp.short_packet);
            bad_words++;
          end
          if (rsp.underrun_total !== want.underrun_total) begin
            $error("underrun_total: expected %0d, got %0d",
                   want.underrun_total, rsp.underrun_total);
            bad_words++;
          end
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STREAM_ENABLE) streaming = cfg_data[0];
        else if (cfg_index == REG_PACKET_LENGTH) packet_len = cfg_data;
      end

      // Advance the model on each accepted input word
      if (req_valid && req_ready) begin
        if (req.func == FUNC_PUSH) begin
          if (held_count < effective_len()) begin
            held_samples[held_count] = req.sample_in;
            held_count++;
          end
        end else begin
          predict_packet();
        end
      end
    end
    mismatches <= bad_words;
    outstanding <= expected_words.size();
  end

endmodule

// ----- dv/tb.sv -----
// Testbench top for the audio packetizer: drives samples, ticks and register
// writes, paces the receiver, and reports the verdict. Uses apkt_checker.
`timescale 1ns / 1ps

module tb;
  import apkt_pkg::*;

  localparam int RANDOM_ITEMS = 400;
  localparam int LONG_HOLD    = 400;
  localparam int SETTLE       = 60;
  localparam int CYCLE_LIMIT  = 1000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int cur_len = MAX_PACKET_SAMPLES_DEF;
  bit burst_mode = 1'b0;
  bit hold_request = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  audio_packetizer_underrun_fade_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  apkt_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: random stalls per word, plus one long hold-off on request
  initial begin : receiver
    int pause;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        rsp_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      pause = burst_mode ? 0 : $urandom_range(0, 9);
      if (pause != 0) begin
        rsp_ready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid && rsp_ready));
      @(negedge clk);
    end
  end

  // Offer one input word after a random gap; return at the negedge after acceptance
  task automatic send_word(input logic func, input logic signed [SAMPLE_W-1:0] value);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: func, sample_in: value};
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] value);
    send_word(FUNC_PUSH, value);
  endtask

  task automatic deadline_tick();
    send_word(FUNC_TICK, SAMPLE_W'($urandom));
  endtask

  // Drop valid, drain every expected word, then let the block go quiet
  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write both registers while idle
  task automatic configure(input logic enable, input logic [CFG_DATA_W-1:0] len);
    settle();
    write_reg(REG_STREAM_ENABLE, CFG_DATA_W'(enable));
    write_reg(REG_PACKET_LENGTH, len);
    cfg_valid <= 1'b0;
    if (len == 0) cur_len = 1;
    else if (len > MAX_PACKET_SAMPLES_DEF) cur_len = MAX_PACKET_SAMPLES_DEF;
    else cur_len = len;
  endtask

  // Sample values biased toward the extremes and near zero
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int items_sent;
    int pick;
    int count;
    logic [CFG_DATA_W-1:0] new_len;
    items_sent = 0;

    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Full packet of extremes, fifth sample dropped on a full store
    configure(1'b1, 5'd4);
    push_sample(16'sh7FFF);
    push_sample(16'sh5555);
    push_sample(-1);
    push_sample(16'sh8000);
    push_sample(123);
    deadline_tick();
    // Empty packet fades from the last word sent
    deadline_tick();
    // Short packet fades from the last stored sample
    push_sample(-30000);
    deadline_tick();
    // Length zero behaves as one
    configure(1'b1, 5'd0);
    push_sample(7);
    push_sample(8);
    deadline_tick();
    // Length above the store depth behaves as the depth
    configure(1'b1, 5'd31);
    push_sample(1000);
    push_sample(-2);
    deadline_tick();
    // Lower the length below the fill; the extra samples are discarded
    configure(1'b1, 5'd8);
    push_sample(11);
    push_sample(12);
    push_sample(13);
    push_sample(14);
    push_sample(15);
    configure(1'b1, 5'd3);
    deadline_tick();
    // Tick with streaming off clears fill and last word; pushes still stored
    configure(1'b0, 5'd3);
    push_sample(5);
    deadline_tick();
    push_sample(9);
    configure(1'b1, 5'd3);
    deadline_tick();

    // Long receiver hold-off while full packets keep coming
    configure(1'b1, 5'd16);
    hold_request = 1'b1;
    repeat (3) begin
      for (int i = 0; i < MAX_PACKET_SAMPLES_DEF; i++) push_sample(pick_sample());
      deadline_tick();
      items_sent += MAX_PACKET_SAMPLES_DEF + 1;
    end

    // Random phases: new settings, then push-and-tick sequences
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) new_len = 5'd0;
      else if (pick == 1) new_len = 5'd1;
      else if (pick == 2) new_len = 5'd16;
      else if (pick == 3) new_len = CFG_DATA_W'($urandom_range(17, 31));
      else new_len = CFG_DATA_W'($urandom_range(1, 16));
      configure($urandom_range(0, 5) != 0, new_len);
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 10)) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) count = cur_len;
        else if (pick < 7) count = $urandom_range(0, cur_len);
        else if (pick < 8) count = 0;
        else count = cur_len + $urandom_range(1, 3);
        repeat (count) push_sample(pick_sample());
        deadline_tick();
        items_sent += ((count < cur_len) ? count : cur_len) + 1;
      end
      burst_mode = 1'b0;
    end

    // Drain and report
    settle();
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/apkt_pkg.sv
hdl/apkt_store.sv
hdl/apkt_fade.sv
hdl/audio_packetizer_underrun_fade_top.sv
dv/apkt_checker.sv
dv/tb.sv
